// ===== rtl/tvt_pkg.sv =====
// Shared types, character codes and the name-byte classifier for the template tokenizer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package tvt_pkg;

	// Result kinds as they appear in the low bits of m_tuser
	typedef enum logic [1:0] {
		KIND_LIT  = 2'd0,
		KIND_NAME = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// Scanner mode across input bytes
	typedef enum logic [1:0] {
		MODE_TEXT   = 2'd0,
		MODE_DOLLAR = 2'd1,
		MODE_NAME   = 2'd2,
		MODE_ERROR  = 2'd3
	} mode_t;

	// Controller sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BYTE,
		ST_BRACE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	// Source of the result value
	typedef enum logic [2:0] {
		OSEL_IN,
		OSEL_DOLLAR,
		OSEL_BRACE,
		OSEL_HELD,
		OSEL_MEM,
		OSEL_ERR
	} osel_t;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_LBRACE = 8'h7B;
	localparam logic [7:0] CHAR_RBRACE = 8'h7D;
	localparam logic [7:0] CHAR_UNDER  = 8'h5F;
	localparam logic [7:0] CHAR_LBRACK = 8'h5B;
	localparam logic [7:0] CHAR_RBRACK = 8'h5D;
	localparam logic [7:0] CHAR_DASH   = 8'h2D;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_AT     = 8'h40;

	// Commands from controller to datapath
	typedef struct packed {
		logic   load;      // load the result register
		osel_t  sel;       // value source
		kind_t  kind;
		logic   name_end;
		logic   tend;
		logic   hold;      // capture input byte and last flag
		logic   store;     // append input byte to the name store
		logic   clr_len;
		logic   idx_clr;
		logic   idx_inc;
		logic   fetch;     // read name store at the burst index
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic can_load;
		logic in_dollar;
		logic in_lbrace;
		logic in_rbrace;
		logic in_name;
		logic in_last;
		logic held_last;
		logic len_zero;
		logic len_full;
		logic idx_last;
	} dp_sts_t;

	function automatic logic is_name_byte(input logic [7:0] b);
		logic alnum;
		alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A);
		return alnum || b == CHAR_UNDER || b == CHAR_LBRACK || b == CHAR_RBRACK ||
			b == CHAR_DASH || b == CHAR_DOT || b == CHAR_STAR || b == CHAR_AT;
	endfunction

endpackage

// ===== rtl/tvt_datapath.sv =====
// Datapath of the template tokenizer: name store memory, length and burst counters,
// held byte, and the result register. Depends on tvt_pkg.
`timescale 1ns / 1ps

module tvt_datapath #(
	parameter int NAME_MAX = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      s_tdata,
	input  logic            s_tlast,
	input  tvt_pkg::dp_cmd_t cmd,
	output tvt_pkg::dp_sts_t sts,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	output logic [2:0]      m_tuser
);
	import tvt_pkg::*;

	localparam int LEN_W = $clog2(NAME_MAX + 1);
	localparam int IDX_W = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

	logic [7:0]       mem [NAME_MAX];
	logic [7:0]       rd_data_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] idx_q;

	logic             out_valid_q;
	logic [7:0]       out_value_q;
	kind_t            out_kind_q;
	logic             out_name_end_q;
	logic             out_tend_q;
	logic [7:0]       value_d;

	always_ff @(posedge clk) begin
		if (cmd.store)
			mem[len_q[IDX_W-1:0]] <= s_tdata;
		if (cmd.fetch)
			rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			byte_q <= s_tdata;
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.clr_len)
				len_q <= '0;
			else if (cmd.store)
				len_q <= len_q + LEN_W'(1);
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_comb begin
		case (cmd.sel)
			OSEL_IN:     value_d = s_tdata;
			OSEL_DOLLAR: value_d = CHAR_DOLLAR;
			OSEL_BRACE:  value_d = CHAR_LBRACE;
			OSEL_HELD:   value_d = byte_q;
			OSEL_MEM:    value_d = rd_data_q;
			default:     value_d = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_value_q    <= value_d;
			out_kind_q     <= cmd.kind;
			out_name_end_q <= cmd.name_end;
			out_tend_q     <= cmd.tend;
		end
	end

	assign sts.can_load  = !out_valid_q || m_tready;
	assign sts.in_dollar = s_tdata == CHAR_DOLLAR;
	assign sts.in_lbrace = s_tdata == CHAR_LBRACE;
	assign sts.in_rbrace = s_tdata == CHAR_RBRACE;
	assign sts.in_name   = is_name_byte(s_tdata);
	assign sts.in_last   = s_tlast;
	assign sts.held_last = last_q;
	assign sts.len_zero  = len_q == '0;
	assign sts.len_full  = len_q == LEN_W'(NAME_MAX);
	assign sts.idx_last  = (LEN_W'(idx_q) + LEN_W'(1)) == len_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_tend_q;
	assign m_tuser  = {out_name_end_q, out_kind_q};

endmodule

// ===== rtl/tvt_ctrl.sv =====
// Controller of the template tokenizer: scan mode register and the result sequencer.
// Depends on tvt_pkg; drives tvt_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module tvt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  tvt_pkg::dp_sts_t sts,
	output tvt_pkg::dp_cmd_t cmd
);
	import tvt_pkg::*;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   burst_name_q, burst_name_d;
	logic   take;
	logic   name_err;

	assign take     = (state_q == ST_IDLE) && s_tvalid && sts.can_load;
	assign name_err = sts.in_rbrace ? sts.len_zero : (!sts.in_name || sts.len_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= MODE_TEXT;
			burst_name_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			mode_q       <= mode_d;
			burst_name_q <= burst_name_d;
		end
	end

	// Next state and scan mode
	always_comb begin
		state_d      = state_q;
		mode_d       = mode_q;
		burst_name_d = burst_name_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (mode_q)
						MODE_TEXT: begin
							if (sts.in_dollar)
								mode_d = MODE_DOLLAR;
						end
						MODE_DOLLAR: begin
							if (sts.in_dollar) begin
								mode_d = MODE_TEXT;
							end else if (sts.in_lbrace) begin
								mode_d = MODE_NAME;
								if (sts.in_last)
									state_d = ST_BRACE;
							end else begin
								mode_d  = MODE_TEXT;
								state_d = ST_BYTE;
							end
						end
						MODE_NAME: begin
							if (name_err) begin
								mode_d = MODE_ERROR;
							end else if (sts.in_rbrace) begin
								mode_d       = MODE_TEXT;
								state_d      = ST_FETCH;
								burst_name_d = 1'b1;
							end else if (sts.in_last) begin
								state_d      = ST_BRACE;
								burst_name_d = 1'b0;
							end
						end
						MODE_ERROR: ;
					endcase
					if (sts.in_last)
						mode_d = MODE_TEXT;
				end
			end
			ST_BYTE: begin
				if (sts.can_load)
					state_d = ST_IDLE;
			end
			ST_BRACE: begin
				if (sts.can_load)
					state_d = sts.len_zero ? ST_IDLE : ST_FETCH;
			end
			ST_FETCH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.can_load)
					state_d = sts.idx_last ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd      = '0;
		cmd.sel  = OSEL_IN;
		cmd.kind = KIND_LIT;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = sts.can_load;
				if (take) begin
					unique case (mode_q)
						MODE_TEXT: begin
							if (!sts.in_dollar) begin
								cmd.load = 1'b1;
								cmd.tend = sts.in_last;
							end else if (sts.in_last) begin
								cmd.load = 1'b1;
								cmd.sel  = OSEL_DOLLAR;
								cmd.tend = 1'b1;
							end
						end
						MODE_DOLLAR: begin
							if (sts.in_dollar) begin
								cmd.load = 1'b1;
								cmd.sel  = OSEL_DOLLAR;
								cmd.tend = sts.in_last;
							end else if (sts.in_lbrace) begin
								cmd.clr_len = 1'b1;
								if (sts.in_last) begin
									cmd.load = 1'b1;
									cmd.sel  = OSEL_DOLLAR;
									cmd.hold = 1'b1;
								end
							end else begin
								cmd.load = 1'b1;
								cmd.sel  = OSEL_DOLLAR;
								cmd.hold = 1'b1;
							end
						end
						MODE_NAME: begin
							if (name_err) begin
								cmd.load    = 1'b1;
								cmd.sel     = OSEL_ERR;
								cmd.kind    = KIND_ERR;
								cmd.tend    = 1'b1;
								cmd.clr_len = 1'b1;
							end else if (sts.in_rbrace) begin
								cmd.hold    = 1'b1;
								cmd.idx_clr = 1'b1;
							end else begin
								cmd.store = 1'b1;
								if (sts.in_last) begin
									cmd.load = 1'b1;
									cmd.sel  = OSEL_DOLLAR;
									cmd.hold = 1'b1;
								end
							end
						end
						MODE_ERROR: ;
					endcase
				end
			end
			ST_BYTE: begin
				if (sts.can_load) begin
					cmd.load = 1'b1;
					cmd.sel  = OSEL_HELD;
					cmd.tend = sts.held_last;
				end
			end
			ST_BRACE: begin
				if (sts.can_load) begin
					cmd.load    = 1'b1;
					cmd.sel     = OSEL_BRACE;
					cmd.tend    = sts.held_last && sts.len_zero;
					cmd.idx_clr = 1'b1;
				end
			end
			ST_FETCH: cmd.fetch = 1'b1;
			ST_EMIT: begin
				if (sts.can_load) begin
					cmd.load     = 1'b1;
					cmd.sel      = OSEL_MEM;
					cmd.kind     = burst_name_q ? KIND_NAME : KIND_LIT;
					cmd.name_end = burst_name_q && sts.idx_last;
					cmd.tend     = sts.held_last && sts.idx_last;
					if (sts.idx_last)
						cmd.clr_len = 1'b1;
					else
						cmd.idx_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/template_variable_tokenizer_top.sv =====
// A direct result is valid the cycle after the transfer that causes it; the first byte of a
// name burst follows the closing brace through ST_FETCH (store read) and then ST_EMIT.
// Plain text bytes, $$ and a lone $ go at one input byte per cycle unless the output stalls;
// a byte after a lone $ is held and sent from ST_BYTE, which stalls the input, as does a
// closing brace or an unclosed name at template end while ST_FETCH and ST_EMIT send the name.
// Reset (arst_n low, asynchronous): text mode, name length zero, output empty; store kept.
`timescale 1ns / 1ps

module template_variable_tokenizer_top #(
	parameter int NAME_MAX = 32   // longest accepted variable name, 1 to 60
) (
	input  logic       clk,
	input  logic       arst_n,
	// Input stream: one template byte per transfer
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_in
	input  logic       s_tlast,   // last_byte: final byte of the template
	// Result stream: one token byte per transfer
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] value (zero on error)
	output logic       m_tlast,   // template_end: final result of the template
	output logic [2:0] m_tuser    // [1:0] kind, [2] name_end
);
	import tvt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Controller: holds the scan mode, decides per transfer which results to produce,
	// and steps through the literal prefix and the name burst.
	tvt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: buffers name bytes, classifies the incoming byte, and holds the
	// result register that decouples the two stream sides.
	tvt_datapath #(
		.NAME_MAX(NAME_MAX)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.cmd     (cmd),
		.sts     (sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// ===== rtl/tvt_checker.sv =====
// Port-level checks for the template tokenizer, bound to the top level.
// Depends on the top level's ports and the result kinds in tvt_pkg.
`timescale 1ns / 1ps

module tvt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [2:0] m_tuser
);
	import tvt_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An error result ends the template and carries zero
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == KIND_ERR |-> m_tlast && m_tdata == 8'h00)
		else $error("malformed error result");

	// Only name bytes end a name
	a_name_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == KIND_NAME)
		else $error("name_end on a non-name result");

	// Only the defined kinds are produced
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] == KIND_LIT || m_tuser[1:0] == KIND_NAME ||
			m_tuser[1:0] == KIND_ERR)
		else $error("undefined result kind");

endmodule

bind template_variable_tokenizer_top tvt_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

// ===== verif/tvt_token_checker.sv =====
// Token checker for the template tokenizer: watches both streams, predicts the token bytes
// for every accepted template byte and compares each result transfer against the prediction.
// Depends on tvt_pkg for the result kinds, scanner modes and character codes.
`timescale 1ns / 1ps

module tvt_token_checker #(
	parameter int NAME_MAX = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic [2:0] m_tuser,
	output int         mismatches,
	output int         outstanding
);
	import tvt_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
		logic       name_end;
		logic       tend;
	} token_t;

	token_t     pending_tokens[$];
	mode_t      scan_state = MODE_TEXT;
	logic [7:0] name_buf [NAME_MAX];
	int         name_len = 0;

	function automatic bit name_char_ok(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
			c == CHAR_UNDER || c == CHAR_LBRACK || c == CHAR_RBRACK || c == CHAR_DASH ||
			c == CHAR_DOT || c == CHAR_STAR || c == CHAR_AT;
	endfunction

	function automatic void add_token(input kind_t k, input logic [7:0] v, input logic ne,
			input logic te);
		token_t t;
		t.kind     = k;
		t.value    = v;
		t.name_end = ne;
		t.tend     = te;
		pending_tokens.push_back(t);
	endfunction

	// Advance the scanner by one template byte and queue the tokens it gives out
	function automatic void scan_byte(input logic [7:0] b, input logic last);
		int base;
		bit err;
		base = pending_tokens.size();
		err  = 0;
		case (scan_state)
			MODE_TEXT: begin
				if (b == CHAR_DOLLAR)
					scan_state = MODE_DOLLAR;
				else
					add_token(KIND_LIT, b, 1'b0, 1'b0);
			end
			MODE_DOLLAR: begin
				if (b == CHAR_DOLLAR) begin
					add_token(KIND_LIT, CHAR_DOLLAR, 1'b0, 1'b0);
					scan_state = MODE_TEXT;
				end else if (b == CHAR_LBRACE) begin
					scan_state = MODE_NAME;
					name_len   = 0;
				end else begin
					add_token(KIND_LIT, CHAR_DOLLAR, 1'b0, 1'b0);
					add_token(KIND_LIT, b, 1'b0, 1'b0);
					scan_state = MODE_TEXT;
				end
			end
			MODE_NAME: begin
				if (b == CHAR_RBRACE) begin
					if (name_len == 0) begin
						err = 1;
					end else begin
						for (int i = 0; i < name_len; i++)
							add_token(KIND_NAME, name_buf[i], i == name_len - 1, 1'b0);
						name_len   = 0;
						scan_state = MODE_TEXT;
					end
				end else if (!name_char_ok(b) || name_len >= NAME_MAX) begin
					err = 1;
				end else begin
					name_buf[name_len] = b;
					name_len++;
				end
			end
			default: ;
		endcase
		if (err) begin
			add_token(KIND_ERR, 8'h00, 1'b0, 1'b1);
			scan_state = MODE_ERROR;
			name_len   = 0;
		end
		if (last) begin
			if (scan_state == MODE_DOLLAR) begin
				add_token(KIND_LIT, CHAR_DOLLAR, 1'b0, 1'b0);
			end else if (scan_state == MODE_NAME) begin
				add_token(KIND_LIT, CHAR_DOLLAR, 1'b0, 1'b0);
				add_token(KIND_LIT, CHAR_LBRACE, 1'b0, 1'b0);
				for (int i = 0; i < name_len; i++)
					add_token(KIND_LIT, name_buf[i], 1'b0, 1'b0);
			end
			if (pending_tokens.size() > base)
				pending_tokens[pending_tokens.size() - 1].tend = 1'b1;
			scan_state = MODE_TEXT;
			name_len   = 0;
		end
	endfunction

	always @(posedge clk) begin
		token_t want;
		if (!arst_n) begin
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				scan_byte(s_tdata, s_tlast);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (pending_tokens.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result kind=%0d value=%02h name_end=%b tend=%b",
							$realtime, m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
					mismatches++;
				end else begin
					want = pending_tokens.pop_front();
					if (m_tuser[1:0] !== want.kind || m_tdata !== want.value ||
							m_tuser[2] !== want.name_end || m_tlast !== want.tend) begin
						if (mismatches < 10)
							$display({"%0t: token mismatch: expected kind=%0d value=%02h ",
								"name_end=%b tend=%b, got kind=%0d value=%02h name_end=%b tend=%b"},
								$realtime, want.kind, want.value, want.name_end, want.tend,
								m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
						mismatches++;
					end
				end
			end
			outstanding <= pending_tokens.size();
		end
	end

endmodule

// ===== verif/tb_template_variable_tokenizer_top.sv =====
// Testbench top for the template tokenizer: drives template bytes with random gaps and output
// stalls, hands both streams to tvt_token_checker and prints the verdict.
// Depends on tvt_pkg, template_variable_tokenizer_top and tvt_token_checker.
`timescale 1ns / 1ps

module tb_template_variable_tokenizer_top;
	import tvt_pkg::*;

	localparam int NAME_MAX   = 32;
	localparam int RAND_ITEMS = 130;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [2:0] m_tuser;

	int mismatches;
	int outstanding;

	// calm: a stretch where neither side idles
	bit         calm = 0;
	logic [7:0] tmpl[$];
	int         live_total = 0;

	string ident   = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_[]-.*@";
	string bad_set = " !\"#%&'()+,/:;<=>?\\^|~${";

	template_variable_tokenizer_top #(
		.NAME_MAX(NAME_MAX)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	tvt_token_checker #(
		.NAME_MAX(NAME_MAX)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: drops ready at random with a chance of 16 in 100, never during the calm stretch
	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 16);
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [7:0] ident_char();
		return ident[$urandom_range(ident.len() - 1)];
	endfunction

	// A byte that may not appear inside a name: punctuation, '$', '{', control or high bytes
	function automatic logic [7:0] bad_char();
		case ($urandom_range(3))
			0:       return 8'($urandom_range(8'h80, 8'hFF));
			1:       return 8'($urandom_range(8'h00, 8'h1F));
			default: return bad_set[$urandom_range(bad_set.len() - 1)];
		endcase
	endfunction

	function automatic void queue_str(input string s);
		for (int i = 0; i < s.len(); i++)
			tmpl.push_back(s[i]);
	endfunction

	// Offer one byte; maybe hold off first, then wait for the transfer
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Send the queued template, marking its final byte
	task automatic send_tmpl();
		for (int i = 0; i < tmpl.size(); i++)
			send_byte(tmpl[i], i == tmpl.size() - 1);
		tmpl.delete();
	endtask

	// Drop valid and hold until every predicted token has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Build one random template. force_len > 0 makes a single name of exactly that length.
	// Returns the number of bytes the block acts on (bytes after an error are not counted).
	task automatic build_template(input int force_len, output int live);
		int  pick;
		bit  stop;
		bit  broken;
		stop   = 0;
		broken = 0;
		live   = 0;
		tmpl.delete();
		if (force_len > 0) begin
			queue_str("${");
			repeat (force_len) tmpl.push_back(ident_char());
			// an overflowing name errors on its last byte, so the brace is ignored
			broken = force_len > NAME_MAX;
			if (broken)
				live = tmpl.size();
			tmpl.push_back(CHAR_RBRACE);
		end else begin
			for (int s = $urandom_range(1, 4); s > 0 && !stop; s--) begin
				pick = $urandom_range(99);
				if (pick < 30) begin
					repeat ($urandom_range(1, 5)) tmpl.push_back(8'($urandom_range(255)));
				end else if (pick < 40) begin
					queue_str("$$");
				end else if (pick < 50) begin
					tmpl.push_back(CHAR_DOLLAR);
					tmpl.push_back(8'($urandom_range(255)));
				end else if (pick < 85) begin
					queue_str("${");
					repeat ($urandom_range(1, 8)) tmpl.push_back(ident_char());
					tmpl.push_back(CHAR_RBRACE);
				end else if (pick < 90) begin
					// bad byte inside a name
					queue_str("${");
					repeat ($urandom_range(0, 3)) tmpl.push_back(ident_char());
					tmpl.push_back(bad_char());
					stop   = 1;
					broken = 1;
				end else if (pick < 93) begin
					queue_str("${}");
					stop   = 1;
					broken = 1;
				end else if (pick < 97) begin
					// end the template inside an open name
					queue_str("${");
					repeat ($urandom_range(0, 5)) tmpl.push_back(ident_char());
					stop = 1;
				end else begin
					tmpl.push_back(CHAR_DOLLAR);
					stop = 1;
				end
			end
			if (broken)
				live = tmpl.size();
		end
		if (broken) begin
			// trailing bytes the block skips until the end marker
			repeat ($urandom_range(0, 3)) tmpl.push_back(8'($urandom_range(255)));
		end else begin
			live = tmpl.size();
		end
	endtask

	initial begin
		int  live;
		int  forced;
		bit  drained;
		forced  = 0;
		drained = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, escaped dollar, bare dollar, a name, end right after '$'
		tmpl.push_back(8'h00);
		tmpl.push_back(8'hFF);
		queue_str("$$$a${A_z9}$");
		send_tmpl();
		// empty name: error, then skip to the end marker
		queue_str("${}q");
		send_tmpl();
		// end inside an unclosed name
		queue_str("${ab");
		send_tmpl();
		drain();

		// Random templates; the first two hit the longest name and the overflow
		while (live_total < RAND_ITEMS) begin
			calm = live_total >= 40 && live_total < 80;
			if (forced == 0)
				build_template(NAME_MAX, live);
			else if (forced == 1)
				build_template(NAME_MAX + 1, live);
			else
				build_template(0, live);
			forced++;
			send_tmpl();
			live_total += live;
			if (!drained && live_total >= 65) begin
				drain();
				drained = 1;
			end
		end
		calm = 0;

		drain();
		// watch for stray results after the last token
		repeat (100) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
